### rtl/core/ascii_content_packet_capper_assert.svh
// Assertion macros shared by the packet capper RTL.
`ifndef ASCII_CONTENT_PACKET_CAPPER_ASSERT_SVH
`define ASCII_CONTENT_PACKET_CAPPER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ACP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acp assertion failed in %m");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ACP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acp assertion failed in %m");

`endif

### rtl/core/acp_pkg.sv
// Shared types, register indexes and decision codes of the packet capper.
`default_nettype none

package acp_pkg;

  // Default width of the per-packet counters.
  localparam int LENGTH_WIDTH_DEF = 16;

  // Width of the length fields on the result channel.
  localparam int OUT_LEN_W = 16;

  // Scale of the printable share test.
  localparam int PERCENT_SCALE = 100;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ASCII_RUN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ASCII_PERCENT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPPED_LENGTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PRINTABLE_LOW    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PRINTABLE_HIGH   = 3'd5;

  // Register values after reset.
  localparam logic [15:0] RST_ASCII_RUN_LENGTH = 16'd16;
  localparam logic [6:0]  RST_ASCII_PERCENT    = 7'd50;
  localparam logic [15:0] RST_HEADER_SKIP      = 16'd42;
  localparam logic [15:0] RST_CAPPED_LENGTH    = 16'd64;
  localparam logic [6:0]  RST_PRINTABLE_LOW    = 7'd32;
  localparam logic [6:0]  RST_PRINTABLE_HIGH   = 7'd126;

  // Decision codes on the result channel.
  localparam logic [1:0] DEC_SHORT_KEPT   = 2'd0;
  localparam logic [1:0] DEC_RUN_CAPPED   = 2'd1;
  localparam logic [1:0] DEC_RATIO_KEPT   = 2'd2;
  localparam logic [1:0] DEC_RATIO_CAPPED = 2'd3;

  // Configuration register file as seen by the datapath.
  typedef struct packed {
    logic [15:0] ascii_run_length;
    logic [6:0]  ascii_percent;
    logic [15:0] header_skip;
    logic [15:0] capped_length;
    logic [6:0]  printable_low;
    logic [6:0]  printable_high;
  } acp_cfg_t;

endpackage

`default_nettype wire

### rtl/core/acp_scan.sv
// Per-packet byte counters: position, printable run, printable count and run flag.
`default_nettype none
`include "ascii_content_packet_capper_assert.svh"

module acp_scan
  import acp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire acp_cfg_t                cfg,
  input  wire logic                    step,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last_byte,
  output logic [LENGTH_WIDTH-1:0]      len_nxt,
  output logic [LENGTH_WIDTH-1:0]      pcount_nxt,
  output logic                         found_nxt
);

  // Compare width that holds both the counters and the 16-bit registers.
  localparam int CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);

  logic [LENGTH_WIDTH-1:0] pos_r;
  logic [LENGTH_WIDTH-1:0] run_r;
  logic [LENGTH_WIDTH-1:0] pcount_r;
  logic                    found_r;

  logic [LENGTH_WIDTH-1:0] run_inc;
  logic [LENGTH_WIDTH-1:0] pcount_inc;
  logic [LENGTH_WIDTH-1:0] run_nxt;
  logic                    scan_en;
  logic                    is_print;

  // Bytes at or past the header are scanned until a run has been found.
  assign scan_en = !found_r && (CW'(pos_r) >= CW'(cfg.header_skip));

  // Only 7-bit values inside the configured range count as printable.
  assign is_print = !data_byte[7] && (data_byte[6:0] >= cfg.printable_low)
                    && (data_byte[6:0] <= cfg.printable_high);

  // Saturating increments.
  assign run_inc    = (run_r == LEN_MAX) ? run_r : run_r + LEN_ONE;
  assign pcount_inc = (pcount_r == LEN_MAX) ? pcount_r : pcount_r + LEN_ONE;
  assign len_nxt    = (pos_r == LEN_MAX) ? pos_r : pos_r + LEN_ONE;

  // Counter updates for the byte at the head of the pipeline.
  always_comb begin
    run_nxt    = run_r;
    pcount_nxt = pcount_r;
    found_nxt  = found_r;
    if (scan_en) begin
      if (is_print) begin
        run_nxt    = run_inc;
        pcount_nxt = pcount_inc;
        if (CW'(run_inc) == CW'(cfg.ascii_run_length)) begin
          found_nxt = 1'b1;
        end
      end else begin
        run_nxt = '0;
      end
    end
  end

  // Counters advance on each transfer and clear after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      run_r    <= '0;
      pcount_r <= '0;
      found_r  <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        pos_r    <= '0;
        run_r    <= '0;
        pcount_r <= '0;
        found_r  <= 1'b0;
      end else begin
        pos_r    <= len_nxt;
        run_r    <= run_nxt;
        pcount_r <= pcount_nxt;
        found_r  <= found_nxt;
      end
    end
  end

  // A printable byte is always also a counted byte, and a run is part of the count.
  `ACP_ASSERT_IMP(a_pcount_le_pos, 1'b1, pcount_r <= pos_r)
  `ACP_ASSERT_IMP(a_run_le_pcount, 1'b1, run_r <= pcount_r)
  `ACP_ASSERT_NXT(a_clear_after_last, step && last_byte,
                  pos_r == '0 && pcount_r == '0 && !found_r)

endmodule

`default_nettype wire

### rtl/core/acp_decide.sv
// Capture decision for one finished packet from its final counter values.
`default_nettype none

module acp_decide
  import acp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire acp_cfg_t               cfg,
  input  wire logic [LENGTH_WIDTH-1:0] len,
  input  wire logic [LENGTH_WIDTH-1:0] pcount,
  input  wire logic                   found,
  output logic [OUT_LEN_W-1:0]        packet_length,
  output logic [OUT_LEN_W-1:0]        capture_length,
  output logic [1:0]                  decision
);

  localparam int CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;
  // Signed product width: payload (CW+1) times a 7-bit percent and its sign bit.
  localparam int PW = CW + 9;

  logic [CW-1:0]        len_ext;
  logic signed [PW-1:0] payload_s;
  logic signed [PW-1:0] score_s;
  logic signed [PW-1:0] need_s;

  assign len_ext = CW'(len);

  // Ratio test: 100 * printable >= percent * (length - header), signed.
  assign payload_s = $signed(PW'(len_ext)) - $signed(PW'(cfg.header_skip));
  assign score_s   = $signed(PW'(pcount)) * $signed(PW'(PERCENT_SCALE));
  assign need_s    = payload_s * $signed(PW'(cfg.ascii_percent));

  assign packet_length = OUT_LEN_W'(len);

  // Short packets win over a found run, which wins over the ratio test.
  always_comb begin
    if (len_ext <= CW'(cfg.capped_length)) begin
      capture_length = OUT_LEN_W'(len);
      decision       = DEC_SHORT_KEPT;
    end else if (found) begin
      capture_length = cfg.capped_length;
      decision       = DEC_RUN_CAPPED;
    end else if (score_s >= need_s) begin
      capture_length = OUT_LEN_W'(len);
      decision       = DEC_RATIO_KEPT;
    end else begin
      capture_length = cfg.capped_length;
      decision       = DEC_RATIO_CAPPED;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ascii_content_packet_capper.sv
// Top level of the printable-content packet capper.
//
// Usage: packet bytes enter on the in_ channel, one byte per transfer, with
// in_last_byte set on the final byte of each packet. For every packet exactly
// one result leaves on the out_ channel: the saturated packet length, the
// number of bytes to capture and the decision code.
// Registers are written on the cfg_ channel (cfg_ready is always high). The user
// must write them only while no packet is in flight; the block itself does not
// enforce this. An unknown index is ignored. Throughput: one byte per cycle
// while in_stall is low. The per-byte counter update is the only feedback path.
// Path: a last byte passes the input register, the counter/snapshot register
// and the result register before its result shows on out_valid.
// Stall: out_stall holds the result register. The input keeps flowing while
// non-final bytes arrive; in_stall rises only when a final byte waits, the
// snapshot is full and the result register is full and held by out_stall.
// Reset: rst_n (synchronous) empties the pipeline, clears the packet counters
// and loads the default register values.
`default_nettype none
`include "ascii_content_packet_capper_assert.svh"

module ascii_content_packet_capper
  import acp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Byte channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_last_byte,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [OUT_LEN_W-1:0]        out_packet_length,
  output logic [OUT_LEN_W-1:0]        out_capture_length,
  output logic [1:0]                  out_decision,
  // Configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  acp_cfg_t cfg_r;

  // Input register
  logic       s0_valid_r;
  logic [7:0] s0_data_r;
  logic       s0_last_r;

  // Snapshot of the finished packet's counters
  logic                    s1_valid_r;
  logic [LENGTH_WIDTH-1:0] s1_len_r;
  logic [LENGTH_WIDTH-1:0] s1_pcount_r;
  logic                    s1_found_r;

  // Result register
  logic                 out_valid_r;
  logic [OUT_LEN_W-1:0] out_packet_length_r;
  logic [OUT_LEN_W-1:0] out_capture_length_r;
  logic [1:0]           out_decision_r;

  logic                    s0_step;
  logic                    s1_free;
  logic                    s1_adv;
  logic                    s1_load;
  logic [LENGTH_WIDTH-1:0] scan_len;
  logic [LENGTH_WIDTH-1:0] scan_pcount;
  logic                    scan_found;
  logic [OUT_LEN_W-1:0]    dec_packet_length;
  logic [OUT_LEN_W-1:0]    dec_capture_length;
  logic [1:0]              dec_decision;

  // Pipeline flow: non-final bytes always retire; a final byte needs the snapshot slot.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || s1_adv;
  assign s0_step  = s0_valid_r && (!s0_last_r || s1_free);
  assign s1_load  = s0_step && s0_last_r;
  assign in_stall = s0_valid_r && !s0_step;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ascii_run_length <= RST_ASCII_RUN_LENGTH;
      cfg_r.ascii_percent    <= RST_ASCII_PERCENT;
      cfg_r.header_skip      <= RST_HEADER_SKIP;
      cfg_r.capped_length    <= RST_CAPPED_LENGTH;
      cfg_r.printable_low    <= RST_PRINTABLE_LOW;
      cfg_r.printable_high   <= RST_PRINTABLE_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ASCII_RUN_LENGTH: cfg_r.ascii_run_length <= cfg_data;
        REG_ASCII_PERCENT:    cfg_r.ascii_percent    <= cfg_data[6:0];
        REG_HEADER_SKIP:      cfg_r.header_skip      <= cfg_data;
        REG_CAPPED_LENGTH:    cfg_r.capped_length    <= cfg_data;
        REG_PRINTABLE_LOW:    cfg_r.printable_low    <= cfg_data[6:0];
        REG_PRINTABLE_HIGH:   cfg_r.printable_high   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the three pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s0_valid_r <= in_valid;
      end
      if (s1_free) begin
        s1_valid_r <= s1_load;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload of the pipeline registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s0_data_r <= in_data_byte;
      s0_last_r <= in_last_byte;
    end
    if (s1_load) begin
      s1_len_r    <= scan_len;
      s1_pcount_r <= scan_pcount;
      s1_found_r  <= scan_found;
    end
    if (s1_valid_r && s1_adv) begin
      out_packet_length_r  <= dec_packet_length;
      out_capture_length_r <= dec_capture_length;
      out_decision_r       <= dec_decision;
    end
  end

  acp_scan #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (s0_step),
    .data_byte  (s0_data_r),
    .last_byte  (s0_last_r),
    .len_nxt    (scan_len),
    .pcount_nxt (scan_pcount),
    .found_nxt  (scan_found)
  );

  acp_decide #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_decide (
    .cfg            (cfg_r),
    .len            (s1_len_r),
    .pcount         (s1_pcount_r),
    .found          (s1_found_r),
    .packet_length  (dec_packet_length),
    .capture_length (dec_capture_length),
    .decision       (dec_decision)
  );

  assign out_valid          = out_valid_r;
  assign out_packet_length  = out_packet_length_r;
  assign out_capture_length = out_capture_length_r;
  assign out_decision       = out_decision_r;

  // Kept packets capture their whole length.
  `ACP_ASSERT_IMP(a_kept_whole,
                  out_valid_r && (out_decision_r == DEC_SHORT_KEPT ||
                  out_decision_r == DEC_RATIO_KEPT),
                  out_capture_length_r == out_packet_length_r)
  // The input only waits behind a byte that cannot retire.
  `ACP_ASSERT_IMP(a_stall_needs_last, in_stall, s0_valid_r && s0_last_r && s1_valid_r)
  // A new result always comes from a filled snapshot.
  `ACP_ASSERT_IMP(a_result_from_snapshot, $rose(out_valid_r), $past(s1_valid_r))

endmodule

`default_nettype wire

### test/ascii_content_packet_capper_tb.sv
// Self-checking testbench for the printable-content packet capper.
`timescale 1ns / 100ps

module ascii_content_packet_capper_tb
  import acp_pkg::*;
();

  localparam int LEN_W            = LENGTH_WIDTH_DEF;
  localparam int SINK_HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES     = 6;
  localparam int MAX_REPORTS      = 40;
  localparam int TIMEOUT_NS       = 2_000_000;

  // One verdict on the result channel.
  typedef struct packed {
    logic [OUT_LEN_W-1:0] packet_length;
    logic [OUT_LEN_W-1:0] capture_length;
    logic [1:0]           decision;
  } capper_result_t;

  // One full register setting; the 7-bit registers use the low bits.
  typedef struct packed {
    logic [15:0] run_len;
    logic [15:0] pct;
    logic [15:0] hdr;
    logic [15:0] cap;
    logic [15:0] lo;
    logic [15:0] hi;
  } capper_setting_t;

  // Predicts the capture verdict of each packet and checks the block's verdicts.
  class capper_scoreboard;
    logic [15:0]      run_len;
    logic [6:0]       pct;
    logic [15:0]      hdr;
    logic [15:0]      cap_len;
    logic [6:0]       lo;
    logic [6:0]       hi;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] run;
    logic [LEN_W-1:0] prt;
    bit               found;
    capper_result_t   pending_verdicts[$];
    int               errors;

    function new();
      run_len = RST_ASCII_RUN_LENGTH;
      pct     = RST_ASCII_PERCENT;
      hdr     = RST_HEADER_SKIP;
      cap_len = RST_CAPPED_LENGTH;
      lo      = RST_PRINTABLE_LOW;
      hi      = RST_PRINTABLE_HIGH;
      errors  = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pos   = '0;
      run   = '0;
      prt   = '0;
      found = 1'b0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ASCII_RUN_LENGTH: run_len = val;
        REG_ASCII_PERCENT:    pct     = val[6:0];
        REG_HEADER_SKIP:      hdr     = val;
        REG_CAPPED_LENGTH:    cap_len = val;
        REG_PRINTABLE_LOW:    lo      = val[6:0];
        REG_PRINTABLE_HIGH:   hi      = val[6:0];
        default: ;
      endcase
    endfunction

    // Advance the packet counters by one accepted byte; a last byte yields a verdict.
    function void note_byte(input logic [7:0] b, input logic lst);
      capper_result_t verdict;
      longint         len_i;
      longint         payload;
      longint         score;
      longint         need;
      if (!found && pos >= hdr) begin
        if (b >= lo && b <= hi) begin
          if (run != '1) run++;
          if (prt != '1) prt++;
          if (run == run_len) found = 1'b1;
        end else begin
          run = '0;
        end
      end
      if (pos != '1) pos++;
      if (!lst) return;

      verdict.packet_length = OUT_LEN_W'(pos);
      if (pos <= cap_len) begin
        verdict.capture_length = OUT_LEN_W'(pos);
        verdict.decision       = DEC_SHORT_KEPT;
      end else if (found) begin
        verdict.capture_length = cap_len;
        verdict.decision       = DEC_RUN_CAPPED;
      end else begin
        len_i   = pos;
        payload = len_i - longint'(hdr);
        score   = prt;
        score   = score * PERCENT_SCALE;
        need    = pct;
        need    = need * payload;
        if (score >= need) begin
          verdict.capture_length = OUT_LEN_W'(pos);
          verdict.decision       = DEC_RATIO_KEPT;
        end else begin
          verdict.capture_length = cap_len;
          verdict.decision       = DEC_RATIO_CAPPED;
        end
      end
      pending_verdicts.push_back(verdict);
      clear_packet();
    endfunction

    function void mismatch(input string field, input int unsigned want, input int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(input capper_result_t got);
      capper_result_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                   got.packet_length, got.capture_length, got.decision);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.packet_length !== want.packet_length)
        mismatch("packet_length", want.packet_length, got.packet_length);
      if (got.capture_length !== want.capture_length)
        mismatch("capture_length", want.capture_length, got.capture_length);
      if (got.decision !== want.decision)
        mismatch("decision", want.decision, got.decision);
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_data_byte;
  logic                   in_last_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [OUT_LEN_W-1:0]   out_packet_length;
  logic [OUT_LEN_W-1:0]   out_capture_length;
  logic [1:0]             out_decision;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  capper_scoreboard sb;
  bit               src_idle;
  bit               sink_idle;
  bit               hold_req;

  ascii_content_packet_capper uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_length (out_packet_length),
    .out_capture_length(out_capture_length),
    .out_decision      (out_decision),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Every result transfer is checked against the oldest verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_packet_length, out_capture_length, out_decision});
  end

  // Result sink: random stalls per transfer, plus one long hold on request.
  initial begin : result_sink
    int gap;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = SINK_HOLD_CYCLES;
      end else begin
        gap = sink_idle ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one byte after a random gap and wait for its transfer; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, lst);
    @(negedge clk);
  endtask

  // Pick a byte that is printable under the current setting with the given share.
  function automatic logic [7:0] pick_byte(input int print_share);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < print_share && sb.lo <= sb.hi) begin
      case ($urandom_range(0, 7))
        0:       b = {1'b0, sb.lo};
        1:       b = {1'b0, sb.hi};
        default: b = 8'($urandom_range(sb.lo, sb.hi));
      endcase
    end
    return b;
  endfunction

  task automatic send_packet(input int len, input int print_share);
    for (int i = 0; i < len; i++)
      send_byte(pick_byte(print_share), i == len - 1);
  endtask

  // Register write; cfg_valid stays high for back-to-back writes.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Load a full setting; the 7-bit registers get random upper data bits.
  task automatic apply_setting(input capper_setting_t s);
    write_reg(REG_ASCII_RUN_LENGTH, s.run_len);
    write_reg(REG_ASCII_PERCENT,    {9'($urandom), s.pct[6:0]});
    write_reg(REG_HEADER_SKIP,      s.hdr);
    write_reg(REG_CAPPED_LENGTH,    s.cap);
    write_reg(REG_PRINTABLE_LOW,    {9'($urandom), s.lo[6:0]});
    write_reg(REG_PRINTABLE_HIGH,   {9'($urandom), s.hi[6:0]});
    // An index past the last register must be ignored.
    write_reg(REG_PRINTABLE_HIGH + CFG_INDEX_W'($urandom_range(1, 2)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering bytes and let every verdict, plus the pipeline tail, come out.
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic capper_setting_t random_setting(input int kind);
    capper_setting_t s;
    case (kind)
      // Header longer than any packet, percent above one hundred.
      0: s = '{16'hFFFF, 16'd127, 16'hFFFF, 16'd0, 16'd32, 16'd126};
      // Every packet short, runs found at once.
      1: s = '{16'd1, 16'd50, 16'd0, 16'hFFFF, 16'd32, 16'd126};
      // Inverted printable range with a zero share.
      2: s = '{16'd4, 16'd0, 16'd2, 16'd6, 16'd100, 16'd20};
      // Percent above one hundred with a short header.
      3: s = '{16'd5, 16'd127, 16'd3, 16'd4, 16'd32, 16'd126};
      // Zero run length, full share required.
      4: s = '{16'd0, 16'd100, 16'd0, 16'd5, 16'd0, 16'd127};
      default: begin
        s.run_len = 16'($urandom_range(1, 10));
        s.pct     = 16'($urandom_range(0, 100));
        s.hdr     = 16'($urandom_range(0, 8));
        s.cap     = 16'($urandom_range(0, 16));
        s.lo      = 16'($urandom_range(0, 80));
        s.hi      = 16'($urandom_range(30, 127));
      end
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int len;
    int sent;
    int share;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: two packets around the default capped length.
    for (int p = 0; p < 2; p++)
      send_packet($urandom_range(40, 90), (p == 0) ? 100 : 70);
    end_phase();

    // Directed packets: short, run capped, ratio kept, ratio capped,
    // and a short packet that also found a run.
    apply_setting('{16'd3, 16'd50, 16'd1, 16'd4, 16'd32, 16'd126});
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("A", 1'b0);
    send_byte("B", 1'b0);
    send_byte("C", 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte("A", 1'b0);
    send_byte("A", 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h1F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("a", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte("A", 1'b0);
    send_byte("B", 1'b0);
    send_byte("C", 1'b1);
    end_phase();

    // Random phases, each under its own setting.
    for (int phase = 0; phase < 12; phase++) begin
      apply_setting(random_setting(phase));
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 14) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 20);
        case ($urandom_range(0, 4))
          0:       share = 0;
          1:       share = 30;
          2:       share = 70;
          default: share = 100;
        endcase
        send_packet(len, share);
        sent += len;
      end
      end_phase();
    end

    // Receiver holds off for a long stretch while single-byte packets keep coming.
    apply_setting('{16'd1, 16'd50, 16'd0, 16'd0, 16'd32, 16'd126});
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 1'b1;
    for (int p = 0; p < 40; p++)
      send_byte(8'($urandom), 1'b1);
    end_phase();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
